@@ src/pem_pkg.sv @@
// ----------------------------------------------------------------------------
// Pixel edge marker package
// Shared constants, the result bundle type and the color difference test.
// ----------------------------------------------------------------------------
`default_nettype none

package pem_pkg;

  localparam int PEM_MAX_WIDTH  = 1024;
  localparam int PEM_FIFO_DEPTH = 4;

  localparam int ROW_W   = 12;
  localparam int COL_W   = 10;
  localparam int PIX_W   = 24;
  localparam int CHAN_W  = 8;
  localparam int WIDTH_W = 11;
  localparam int HGT_W   = 13;
  localparam int CFG_W   = 13;

  localparam logic [HGT_W-1:0] MAX_HEIGHT = HGT_W'(4096);

  localparam logic [CHAN_W-1:0] DIFF_ONE   = CHAN_W'(60);
  localparam logic [CHAN_W-1:0] DIFF_TWO   = CHAN_W'(40);
  localparam logic [CHAN_W-1:0] DIFF_THREE = CHAN_W'(20);

  typedef enum logic [0:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_idx_e;

  // Up to three results caused by one pixel: index 0 is the pixel above,
  // index 1 the left neighbor on the last row, index 2 the final pixel.
  typedef struct packed {
    logic [2:0]       valid;
    logic [2:0]       edge_flag;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } bundle_t;

  function automatic logic pem_differs(input logic [PIX_W-1:0] a,
                                       input logic [PIX_W-1:0] b);
    logic [CHAN_W-1:0] x;
    logic [CHAN_W-1:0] y;
    logic [CHAN_W-1:0] d;
    logic [2:0]        g1;
    logic [2:0]        g2;
    logic [2:0]        g3;
    for (int i = 0; i < 3; i++) begin
      x = a[i*CHAN_W +: CHAN_W];
      y = b[i*CHAN_W +: CHAN_W];
      d = (x > y) ? (x - y) : (y - x);
      g1[i] = d > DIFF_ONE;
      g2[i] = d > DIFF_TWO;
      g3[i] = d > DIFF_THREE;
    end
    return (|g1) || (g2[0] && g2[1]) || (g2[1] && g2[2]) || (g2[2] && g2[0]) || (&g3);
  endfunction

endpackage

`default_nettype wire

@@ src/pem_fifo.sv @@
// ----------------------------------------------------------------------------
// Pixel edge marker bundle queue
// Short queue that decouples the classifying front from the result back.
// ----------------------------------------------------------------------------
`default_nettype none

module pem_fifo
  import pem_pkg::*;
#(
  parameter int DEPTH = PEM_FIFO_DEPTH
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire bundle_t wdata_i,
  output logic         full_o,
  input  wire logic    pop_i,
  output logic         empty_o,
  output bundle_t      rdata_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  bundle_t         mem_q [DEPTH];
  logic [PW-1:0]   wptr_q, wptr_d;
  logic [PW-1:0]   rptr_q, rptr_d;
  logic [NW-1:0]   cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = cnt_q == NW'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign rdata_o = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + NW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= NW'(DEPTH))
    else $error("Queue count exceeds its depth.");

endmodule

`default_nettype wire

@@ src/pem_front.sv @@
// ----------------------------------------------------------------------------
// Pixel edge marker front
// Raster counters, two-row line store, neighbor window and edge tests.
// ----------------------------------------------------------------------------
`default_nettype none

module pem_front
  import pem_pkg::*;
#(
  parameter int MAX_WIDTH = PEM_MAX_WIDTH
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [WIDTH_W-1:0] width_i,
  input  wire logic [HGT_W-1:0]   height_i,
  input  wire logic               push_i,
  output logic                    full_o,
  input  wire logic [PIX_W-1:0]   pixel_i,
  output logic                    push_o,
  output bundle_t                 bundle_o,
  input  wire logic               fifo_full_i
);

  localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int LW = (CW + 1 > WIDTH_W) ? CW + 1 : WIDTH_W;
  localparam int AW = CW + 1;

  logic [PIX_W-1:0] mem_q [2**AW];

  logic [CW-1:0]    col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [LW-1:0]    w_ext, w_eff;
  logic [HGT_W-1:0] h_eff;
  logic             last_col, last_row;
  logic             accept, stall;
  logic [AW-1:0]    addr_wr, addr_p;

  logic             s2_valid_q, s2_valid_d;
  logic [ROW_W-1:0] s2_row_q;
  logic [CW-1:0]    s2_col_q;
  logic             s2_lc_q, s2_lr_q;
  logic [PIX_W-1:0] px_q, px_left_q, p_cur_q, p_left_q, rd_p_q, rd_q_q;

  logic             has_a, has_b, has_c;
  logic             edge_a, edge_b, edge_c;

  always_comb begin
    w_ext = LW'(width_i);
    if (w_ext < LW'(2)) begin
      w_eff = LW'(2);
    end else if (w_ext > LW'(MAX_WIDTH)) begin
      w_eff = LW'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    if (height_i < HGT_W'(2)) begin
      h_eff = HGT_W'(2);
    end else if (height_i > MAX_HEIGHT) begin
      h_eff = MAX_HEIGHT;
    end else begin
      h_eff = height_i;
    end
  end

  assign last_col = (LW'(col_q) + LW'(1)) >= w_eff;
  assign last_row = (HGT_W'(row_q) + HGT_W'(1)) >= h_eff;

  assign has_a = s2_row_q != '0;
  assign has_b = s2_lr_q && (s2_col_q != '0);
  assign has_c = s2_lr_q && s2_lc_q;

  assign stall  = s2_valid_q && (has_a || has_b || has_c) && fifo_full_i;
  assign full_o = stall;
  assign accept = push_i && !stall;
  assign push_o = s2_valid_q && (has_a || has_b || has_c) && !fifo_full_i;
  assign s2_valid_d = accept || stall;

  assign addr_wr = {row_q[0], col_q};
  assign addr_p  = last_col ? {row_q[0], CW'(0)} : {~row_q[0], col_q + CW'(1)};

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + ROW_W'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s2_valid_q <= 1'b0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mem_q[addr_wr] <= pixel_i;
      rd_q_q         <= mem_q[addr_wr];
      rd_p_q         <= mem_q[addr_p];
      p_cur_q        <= rd_p_q;
      p_left_q       <= p_cur_q;
      px_q           <= pixel_i;
      px_left_q      <= px_q;
      s2_row_q       <= row_q;
      s2_col_q       <= col_q;
      s2_lc_q        <= last_col;
      s2_lr_q        <= last_row;
    end
  end

  always_comb begin
    edge_a = pem_differs(p_cur_q, px_q)
          || ((s2_row_q[ROW_W-1:1] != '0) && pem_differs(p_cur_q, rd_q_q))
          || (!s2_lc_q && pem_differs(p_cur_q, rd_p_q));
    edge_b = pem_differs(px_left_q, px_q) || pem_differs(px_left_q, p_left_q);
    edge_c = pem_differs(px_q, p_cur_q);
  end

  always_comb begin
    bundle_o.valid     = {has_c, has_b, has_a};
    bundle_o.edge_flag = {edge_c, edge_b, edge_a};
    bundle_o.row       = s2_row_q;
    bundle_o.col       = COL_W'(s2_col_q);
  end

  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && last_col && last_row) |=> (row_q == '0 && col_q == '0))
    else $error("Frame did not restart after its last pixel.");

  a_final_has_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && has_c) |-> has_b)
    else $error("Final pixel word lacks its left neighbor result.");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall |=> (s2_valid_q && $stable(s2_row_q) && $stable(s2_col_q)))
    else $error("Stalled stage lost its word.");

endmodule

`default_nettype wire

@@ src/pem_back.sv @@
// ----------------------------------------------------------------------------
// Pixel edge marker back
// Splits each queued bundle into single results, oldest first.
// ----------------------------------------------------------------------------
`default_nettype none

module pem_back
  import pem_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        fifo_empty_i,
  input  wire bundle_t     head_i,
  output logic             fifo_pop_o,
  output logic             empty_o,
  input  wire logic        pop_i,
  output logic [ROW_W-1:0] pixel_row_o,
  output logic [COL_W-1:0] pixel_column_o,
  output logic             is_edge_o,
  output logic             last_of_run_o
);

  logic [2:0] done_q, done_d;
  logic [2:0] rem;
  logic [2:0] sel;
  logic       last;
  logic       fire;

  assign rem  = head_i.valid & ~done_q;
  assign last = (rem & (rem - 3'd1)) == 3'b000;
  assign empty_o = fifo_empty_i;
  assign fire  = pop_i && !fifo_empty_i;
  assign fifo_pop_o = fire && last;

  always_comb begin
    sel            = 3'b000;
    pixel_row_o    = head_i.row;
    pixel_column_o = head_i.col;
    is_edge_o      = head_i.edge_flag[2];
    priority if (rem[0]) begin
      sel            = 3'b001;
      pixel_row_o    = head_i.row - ROW_W'(1);
      is_edge_o      = head_i.edge_flag[0];
    end else if (rem[1]) begin
      sel            = 3'b010;
      pixel_column_o = head_i.col - COL_W'(1);
      is_edge_o      = head_i.edge_flag[1];
    end else begin
      sel            = 3'b100;
    end
    last_of_run_o = last;
  end

  always_comb begin
    done_d = done_q;
    if (fire) begin
      done_d = last ? 3'b000 : (done_q | sel);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 3'b000;
    end else begin
      done_q <= done_d;
    end
  end

  a_head_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fifo_empty_i |-> (rem != 3'b000))
    else $error("Queued bundle has no result left to deliver.");

endmodule

`default_nettype wire

@@ src/pixel_edge_marker.sv @@
// ----------------------------------------------------------------------------
// Pixel edge marker
// Streaming edge marker for 24-bit BGR pixels, one row of delay.
// ----------------------------------------------------------------------------
// Throughput: one pixel per cycle unless the result queue is full; the line
// store gives two reads and one write per cycle. On the last row each pixel
// but the first gives two results (three on the final pixel), and the single
// result port then sets the rate to one result per cycle. Bundles are
// registered, then queued. Reset clears the counters and loads width 640 and
// height 480; the line store is not cleared and needs no clearing pass.
`default_nettype none

module pixel_edge_marker
  import pem_pkg::*;
#(
  parameter int MAX_WIDTH  = PEM_MAX_WIDTH,
  parameter int FIFO_DEPTH = PEM_FIFO_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic             cfg_index_i,
  input  wire logic [CFG_W-1:0] cfg_data_i,
  input  wire logic             push,
  output logic                  full,
  input  wire logic [7:0]       blue_i,
  input  wire logic [7:0]       green_i,
  input  wire logic [7:0]       red_i,
  output logic                  empty,
  input  wire logic             pop,
  output logic [ROW_W-1:0]      pixel_row_o,
  output logic [COL_W-1:0]      pixel_column_o,
  output logic                  is_edge_o,
  output logic                  last_of_run_o
);

  logic [WIDTH_W-1:0] width_q;
  logic [HGT_W-1:0]   height_q;
  logic               f_push, f_full, f_pop, f_empty;
  bundle_t            f_wdata, f_head;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_W'(640);
      height_q <= HGT_W'(480);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i[WIDTH_W-1:0];
        CFG_IMAGE_HEIGHT: height_q <= cfg_data_i[HGT_W-1:0];
        default:          width_q  <= width_q;
      endcase
    end
  end

  pem_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .width_i     (width_q),
    .height_i    (height_q),
    .push_i      (push),
    .full_o      (full),
    .pixel_i     ({red_i, green_i, blue_i}),
    .push_o      (f_push),
    .bundle_o    (f_wdata),
    .fifo_full_i (f_full)
  );

  pem_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .wdata_i (f_wdata),
    .full_o  (f_full),
    .pop_i   (f_pop),
    .empty_o (f_empty),
    .rdata_o (f_head)
  );

  pem_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fifo_empty_i   (f_empty),
    .head_i         (f_head),
    .fifo_pop_o     (f_pop),
    .empty_o        (empty),
    .pop_i          (pop),
    .pixel_row_o    (pixel_row_o),
    .pixel_column_o (pixel_column_o),
    .is_edge_o      (is_edge_o),
    .last_of_run_o  (last_of_run_o)
  );

endmodule

`default_nettype wire

@@ tb/sv/tb_pixel_edge_marker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Pixel edge marker testbench
// Streams BGR pixel words through the marker and checks every mark against
// a predictor of its own. A stimulus table covers the thresholds, the frame
// borders, clamped sizes and sizes changed mid-frame. A full frame with no
// idling and random frames with random idling follow. One long hold on
// the result side fills the block until it stalls its input.
// ----------------------------------------------------------------------------

module tb_pixel_edge_marker;
  import pem_pkg::*;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             is_edge;
    logic             last_of_run;
  } mark_t;

  typedef enum logic [1:0] {
    STEP_PIXEL,
    STEP_WIDTH,
    STEP_HEIGHT
  } step_kind_e;

  typedef struct packed {
    step_kind_e  kind;
    logic [23:0] value;
    logic        has_exp;
    logic        exp_edge;
  } dir_step_t;

  // Pixel values are written as 24'hRRGGBB.
  localparam dir_step_t DIR_STEPS [33] = '{
    '{STEP_PIXEL,  24'h000000, 1'b0, 1'b0},
    '{STEP_PIXEL,  24'h000000, 1'b0, 1'b0},
    '{STEP_PIXEL,  24'hFFFFFF, 1'b0, 1'b0},
    '{STEP_WIDTH,  24'd2,      1'b0, 1'b0},
    '{STEP_HEIGHT, 24'd2,      1'b0, 1'b0},
    '{STEP_PIXEL,  24'h808080, 1'b0, 1'b0},
    '{STEP_PIXEL,  24'h000000, 1'b1, 1'b0},
    '{STEP_PIXEL,  24'hFFFFFF, 1'b1, 1'b1},
    '{STEP_PIXEL,  24'h000000, 1'b0, 1'b0},
    '{STEP_PIXEL,  24'h000000, 1'b0, 1'b0},
    '{STEP_PIXEL,  24'h00003D, 1'b1, 1'b1},
    '{STEP_PIXEL,  24'h00003C, 1'b1, 1'b0},
    '{STEP_PIXEL,  24'h000000, 1'b0, 1'b0},
    '{STEP_PIXEL,  24'h000000, 1'b0, 1'b0},
    '{STEP_PIXEL,  24'h292900, 1'b1, 1'b1},
    '{STEP_PIXEL,  24'h292800, 1'b1, 1'b0},
    '{STEP_PIXEL,  24'h000000, 1'b0, 1'b0},
    '{STEP_PIXEL,  24'h000000, 1'b0, 1'b0},
    '{STEP_PIXEL,  24'h151515, 1'b1, 1'b1},
    '{STEP_PIXEL,  24'h151514, 1'b1, 1'b0},
    '{STEP_PIXEL,  24'hFFFFFF, 1'b0, 1'b0},
    '{STEP_PIXEL,  24'h000000, 1'b0, 1'b0},
    '{STEP_PIXEL,  24'hFFFFFF, 1'b1, 1'b1},
    '{STEP_PIXEL,  24'h000000, 1'b1, 1'b0},
    '{STEP_WIDTH,  24'd1,      1'b0, 1'b0},
    '{STEP_HEIGHT, 24'h001FFF, 1'b0, 1'b0},
    '{STEP_PIXEL,  24'h112233, 1'b0, 1'b0},
    '{STEP_PIXEL,  24'h8899AA, 1'b0, 1'b0},
    '{STEP_PIXEL,  24'hFF00FF, 1'b0, 1'b0},
    '{STEP_PIXEL,  24'h00FF00, 1'b0, 1'b0},
    '{STEP_HEIGHT, 24'd2,      1'b0, 1'b0},
    '{STEP_PIXEL,  24'h123456, 1'b0, 1'b0},
    '{STEP_PIXEL,  24'hFEDCBA, 1'b0, 1'b0}
  };

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic             cfg_index_i;
  logic [CFG_W-1:0] cfg_data_i;
  logic             push;
  logic             full;
  logic [7:0]       blue_i;
  logic [7:0]       green_i;
  logic [7:0]       red_i;
  logic             empty;
  logic             pop;
  logic [ROW_W-1:0] pixel_row_o;
  logic [COL_W-1:0] pixel_column_o;
  logic             is_edge_o;
  logic             last_of_run_o;

  logic [PIX_W-1:0]   line_mem [0:2*PEM_MAX_WIDTH-1];
  int unsigned        col_now;
  int unsigned        row_now;
  logic [WIDTH_W-1:0] width_reg;
  logic [HGT_W-1:0]   height_reg;
  mark_t              edge_marks [$];
  int                 mark_errors;
  bit                 steady_run;
  bit                 hold_req;
  bit                 hold_done;

  pixel_edge_marker i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .push           (push),
    .full           (full),
    .blue_i         (blue_i),
    .green_i        (green_i),
    .red_i          (red_i),
    .empty          (empty),
    .pop            (pop),
    .pixel_row_o    (pixel_row_o),
    .pixel_column_o (pixel_column_o),
    .is_edge_o      (is_edge_o),
    .last_of_run_o  (last_of_run_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic bit colors_differ(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b);
    int d;
    int n_wide = 0;
    int n_mid = 0;
    int n_narrow = 0;
    for (int k = 0; k < 3; k++) begin
      d = int'(a[k*CHAN_W +: CHAN_W]) - int'(b[k*CHAN_W +: CHAN_W]);
      if (d < 0) d = -d;
      if (d > int'(DIFF_ONE)) n_wide++;
      if (d > int'(DIFF_TWO)) n_mid++;
      if (d > int'(DIFF_THREE)) n_narrow++;
    end
    return n_wide > 0 || n_mid >= 2 || n_narrow == 3;
  endfunction

  function automatic int bank_slot(input int unsigned row, input int unsigned col);
    return (row % 2) * PEM_MAX_WIDTH + (col % PEM_MAX_WIDTH);
  endfunction

  function automatic logic [PIX_W-1:0] near_color(input logic [PIX_W-1:0] base);
    logic [PIX_W-1:0] px;
    int v;
    if ($urandom_range(4) == 0) return PIX_W'($urandom);
    for (int k = 0; k < 3; k++) begin
      v = int'(base[k*CHAN_W +: CHAN_W]) + int'($urandom_range(140)) - 70;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      px[k*CHAN_W +: CHAN_W] = CHAN_W'(v);
    end
    return px;
  endfunction

  // Works out the marks that one accepted pixel word releases. A typed edge
  // value, where given, replaces the computed one for the pixel above.
  task automatic predict_marks(input logic [PIX_W-1:0] px, input logic has_exp,
                               input logic exp_edge);
    int unsigned w;
    int unsigned h;
    int unsigned r;
    int unsigned c;
    logic        last_col;
    logic        last_row;
    logic        has_left;
    logic        hit;
    logic [PIX_W-1:0] ctr;
    w = width_reg;
    h = height_reg;
    if (w < 2) w = 2;
    if (w > PEM_MAX_WIDTH) w = PEM_MAX_WIDTH;
    if (h < 2) h = 2;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    r = row_now;
    c = col_now;
    if (c >= PEM_MAX_WIDTH) c = PEM_MAX_WIDTH - 1;
    last_col = c >= w - 1;
    last_row = r >= h - 1;
    has_left = last_row && c >= 1;
    if (r >= 1) begin
      ctr = line_mem[bank_slot(r - 1, c)];
      hit = colors_differ(ctr, px);
      if (r >= 2 && colors_differ(ctr, line_mem[bank_slot(r, c)])) hit = 1'b1;
      if (!last_col && colors_differ(ctr, line_mem[bank_slot(r - 1, c + 1)])) hit = 1'b1;
      if (has_exp) hit = exp_edge;
      edge_marks.push_back('{ROW_W'(r - 1), COL_W'(c), hit, !has_left && !(last_row && last_col)});
    end
    if (has_left) begin
      ctr = line_mem[bank_slot(r, c - 1)];
      hit = colors_differ(ctr, px) || colors_differ(ctr, line_mem[bank_slot(r - 1, c - 1)]);
      edge_marks.push_back('{ROW_W'(r), COL_W'(c - 1), hit, !last_col});
    end
    line_mem[bank_slot(r, c)] = px;
    if (last_row && last_col) begin
      hit = colors_differ(px, line_mem[bank_slot(r - 1, c)]);
      edge_marks.push_back('{ROW_W'(r), COL_W'(c), hit, 1'b1});
    end
    if (last_col) begin
      col_now = 0;
      row_now = last_row ? 0 : r + 1;
    end else begin
      col_now = c + 1;
    end
  endtask

  // Offers one pixel word and waits until it is taken; push stays high.
  task automatic send_pixel(input logic [PIX_W-1:0] px, input logic has_exp = 1'b0,
                            input logic exp_edge = 1'b0);
    if (!steady_run) begin
      while ($urandom_range(99) < 19) begin
        push <= 1'b0;
        @(posedge clk_i);
      end
    end
    push <= 1'b1;
    {red_i, green_i, blue_i} <= px;
    do @(posedge clk_i); while (full);
    predict_marks(px, has_exp, exp_edge);
  endtask

  task automatic settle();
    push <= 1'b0;
    while (edge_marks.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_IMAGE_WIDTH) width_reg = data[WIDTH_W-1:0];
    else height_reg = data[HGT_W-1:0];
    @(posedge clk_i);
  endtask

  task automatic check_mark();
    mark_t want;
    if (edge_marks.size() == 0) begin
      $error("mark with no expectation: row %0d column %0d", pixel_row_o, pixel_column_o);
      mark_errors++;
    end else begin
      want = edge_marks.pop_front();
      if (pixel_row_o !== want.row) begin
        $error("pixel_row expected %0d actual %0d", want.row, pixel_row_o);
        mark_errors++;
      end
      if (pixel_column_o !== want.col) begin
        $error("pixel_column expected %0d actual %0d", want.col, pixel_column_o);
        mark_errors++;
      end
      if (is_edge_o !== want.is_edge) begin
        $error("is_edge expected %0d actual %0d", want.is_edge, is_edge_o);
        mark_errors++;
      end
      if (last_of_run_o !== want.last_of_run) begin
        $error("last_of_run expected %0d actual %0d", want.last_of_run, last_of_run_o);
        mark_errors++;
      end
    end
  endtask

  initial begin
    pop         <= 1'b0;
    mark_errors = 0;
    hold_done   = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) check_mark();
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        pop <= 1'b0;
        repeat (400) @(posedge clk_i);
      end else begin
        pop <= steady_run || ($urandom_range(99) >= 19);
      end
    end
  end

  initial begin
    int                random_sent;
    int unsigned       w;
    logic [PIX_W-1:0]  base;
    rst_ni      <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= CFG_IMAGE_WIDTH;
    cfg_data_i  <= '0;
    push        <= 1'b0;
    blue_i      <= '0;
    green_i     <= '0;
    red_i       <= '0;
    steady_run  = 1'b0;
    hold_req    = 1'b0;
    col_now     = 0;
    row_now     = 0;
    width_reg   = WIDTH_W'(640);
    height_reg  = HGT_W'(480);
    random_sent = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIR_STEPS[i]) begin
      case (DIR_STEPS[i].kind)
        STEP_PIXEL: begin
          send_pixel(DIR_STEPS[i].value, DIR_STEPS[i].has_exp, DIR_STEPS[i].exp_edge);
        end
        STEP_WIDTH: begin
          settle();
          write_reg(CFG_IMAGE_WIDTH, DIR_STEPS[i].value[CFG_W-1:0]);
        end
        default: begin
          settle();
          write_reg(CFG_IMAGE_HEIGHT, DIR_STEPS[i].value[CFG_W-1:0]);
        end
      endcase
    end

    // One full frame with no idling on either side.
    settle();
    steady_run = 1'b1;
    write_reg(CFG_IMAGE_WIDTH, CFG_W'(16));
    write_reg(CFG_IMAGE_HEIGHT, CFG_W'(6));
    base = PIX_W'($urandom);
    repeat (96) send_pixel(near_color(base));
    steady_run = 1'b0;

    settle();
    write_reg(CFG_IMAGE_WIDTH, CFG_W'(8));
    write_reg(CFG_IMAGE_HEIGHT, CFG_W'(8));
    hold_req = 1'b1;
    while (random_sent < 230) begin
      base = PIX_W'($urandom);
      if ($urandom_range(99) < 80) begin
        do begin
          send_pixel(near_color(base));
          random_sent++;
        end while (row_now != 0 || col_now != 0);
      end else begin
        repeat ($urandom_range(1, 10)) begin
          send_pixel(near_color(base));
          random_sent++;
        end
      end
      settle();
      if (row_now == 0 && $urandom_range(1) == 1) begin
        case ($urandom_range(9))
          0:       w = $urandom_range(1);
          1, 2:    w = $urandom_range(7, 16);
          default: w = $urandom_range(2, 6);
        endcase
        write_reg(CFG_IMAGE_WIDTH,
                  CFG_W'(w) | (($urandom_range(7) == 0) ? CFG_W'(13'h1800) : CFG_W'(0)));
      end
      if ($urandom_range(1) == 1) begin
        case ($urandom_range(9))
          0:       w = $urandom_range(1);
          1, 2:    w = $urandom_range(7, 10);
          default: w = $urandom_range(2, 6);
        endcase
        write_reg(CFG_IMAGE_HEIGHT, CFG_W'(w));
      end
    end

    settle();
    if (mark_errors == 0) begin
      $display("pixel_edge_marker verification clean");
    end else begin
      $display("pixel_edge_marker verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("pixel_edge_marker verification failed");
    $finish;
  end

endmodule

@@ pixel_edge_marker.f @@
src/pem_pkg.sv
src/pem_fifo.sv
src/pem_front.sv
src/pem_back.sv
src/pixel_edge_marker.sv
tb/sv/tb_pixel_edge_marker.sv
